@@ rtl/slsp_pkg.sv @@
// Shared constants, types and helpers for the step-limited setpoint planner.
package slsp_pkg;

	localparam int CW      = 32;
	localparam int FB      = 16;
	localparam int SQ_N    = 34;
	localparam int DV_N    = 31;
	localparam int MZ_W    = 48;

	localparam logic [16:0] ALPHA_ONE   = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd32768;
	localparam logic [30:0] STEP_RESET  = 31'd19661;

	typedef enum logic [1:0] {
		REG_DAMPING = 2'd0,
		REG_STEP    = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CW-1:0]   cx;
		logic [CW-1:0]   cy;
		logic [CW-1:0]   cz;
		logic            sx;
		logic            sy;
		logic            sz;
		logic [CW:0]     mx;
		logic [CW:0]     my;
		logic [MZ_W-1:0] mz;
	} carry_t;

	function automatic logic signed [49:0] add_mag(logic [CW-1:0] cur, logic neg,
			logic [MZ_W-1:0] m);
		logic signed [49:0] c;
		logic signed [49:0] d;
		c = $signed({{(50-CW){cur[CW-1]}}, cur});
		d = $signed({2'b00, m});
		return neg ? c - d : c + d;
	endfunction

	function automatic logic [CW-1:0] sat(logic signed [49:0] v);
		logic signed [49:0] hi;
		logic signed [49:0] lo;
		hi = 50'sd2147483647;
		lo = -50'sd2147483648;
		if (v > hi)
			return hi[CW-1:0];
		else if (v < lo)
			return lo[CW-1:0];
		return v[CW-1:0];
	endfunction

endpackage

@@ rtl/step_limited_setpoint_planner.sv @@
// Step-limited setpoint planner: fully pipelined error, length, clip and divide datapath.
//
// Channels: pulse start with the six coordinate inputs (signed Q15.16); busy is
// always low, so a new position pair may be started in every cycle.
// Each result appears on next_x/next_y/next_z/step_clipped for exactly one cycle
// with done high; one result per start, in order. Throughput is one item per cycle.
// The pipeline holds the bit-per-stage square root (34 stages) and the bit-per-stage
// dividers (31 stages) plus 7 stages of error forming, multiplies, summing, clip
// compare and output saturation.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 damping, 1 step limit)
// and cfg_data; cfg_ready is always high. Write only while no item is in flight.
// Reset clears the valid bits of all stages and loads the register defaults
// (damping 0.5, step limit 0.3 m). The receiver cannot stall; results are
// never held back.
module step_limited_setpoint_planner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] dest_x,
	input  logic [31:0] dest_y,
	input  logic [31:0] dest_z,
	input  logic [31:0] cur_x,
	input  logic [31:0] cur_y,
	input  logic [31:0] cur_z,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [31:0] next_x,
	output logic [31:0] next_y,
	output logic [31:0] next_z,
	output logic        step_clipped
);

	localparam int CW = slsp_pkg::CW;
	localparam int SQ_N = slsp_pkg::SQ_N;
	localparam int DV_N = slsp_pkg::DV_N;

	logic [16:0] alpha_q;
	logic [30:0] step_q;
	logic [16:0] alpha_eff;
	logic [16:0] scale;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= slsp_pkg::ALPHA_RESET;
			step_q  <= slsp_pkg::STEP_RESET;
		end else if (cfg_valid) begin
			unique case (slsp_pkg::reg_idx_t'(cfg_index))
				slsp_pkg::REG_DAMPING: alpha_q <= cfg_data[16:0];
				slsp_pkg::REG_STEP:    step_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign alpha_eff = (alpha_q > slsp_pkg::ALPHA_ONE) ? slsp_pkg::ALPHA_ONE : alpha_q;
	assign scale = slsp_pkg::ALPHA_ONE - alpha_eff;

	// stage 1: errors
	logic          v_s1;
	logic [CW:0]   ex_s1, ey_s1, ez_s1;
	logic [CW-1:0] cx_s1, cy_s1, cz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		ex_s1 <= {dest_x[CW-1], dest_x} - {cur_x[CW-1], cur_x};
		ey_s1 <= {dest_y[CW-1], dest_y} - {cur_y[CW-1], cur_y};
		ez_s1 <= {dest_z[CW-1], dest_z} - {cur_z[CW-1], cur_z};
		cx_s1 <= cur_x;
		cy_s1 <= cur_y;
		cz_s1 <= cur_z;
	end

	// stage 2: magnitudes, y damping product
	logic          v_s2;
	logic [CW:0]   mx_s2, mez_s2;
	logic [49:0]   myp_s2;
	logic          sx_s2, sy_s2, sz_s2;
	logic [CW-1:0] cx_s2, cy_s2, cz_s2;
	logic [CW:0]   aby_s1;

	assign aby_s1 = ey_s1[CW] ? -ey_s1 : ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		mx_s2  <= ex_s1[CW] ? -ex_s1 : ex_s1;
		mez_s2 <= ez_s1[CW] ? -ez_s1 : ez_s1;
		myp_s2 <= 50'(aby_s1) * 50'(scale);
		sx_s2  <= ex_s1[CW];
		sy_s2  <= ey_s1[CW];
		sz_s2  <= ez_s1[CW];
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		cz_s2  <= cz_s1;
	end

	// stage 3: x square, x numerator, z step
	logic          v_s3;
	logic [65:0]   sqx_s3;
	logic [63:0]   nmx_s3;
	logic [63:0]   zp;
	slsp_pkg::carry_t c_s3;

	assign zp = 64'(step_q) * 64'(mez_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		sqx_s3  <= 66'(mx_s2) * 66'(mx_s2);
		nmx_s3  <= 64'(step_q) * 64'(mx_s2);
		c_s3.cx <= cx_s2;
		c_s3.cy <= cy_s2;
		c_s3.cz <= cz_s2;
		c_s3.sx <= sx_s2;
		c_s3.sy <= sy_s2;
		c_s3.sz <= sz_s2;
		c_s3.mx <= mx_s2;
		c_s3.my <= myp_s2[48:16];
		c_s3.mz <= zp[63:16];
	end

	// stage 4: y square, y numerator
	logic          v_s4;
	logic [65:0]   sqx_s4, sqy_s4;
	logic [63:0]   nmx_s4, nmy_s4;
	slsp_pkg::carry_t c_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		sqx_s4 <= sqx_s3;
		sqy_s4 <= 66'(c_s3.my) * 66'(c_s3.my);
		nmx_s4 <= nmx_s3;
		nmy_s4 <= 64'(step_q) * 64'(c_s3.my);
		c_s4   <= c_s3;
	end

	// stage 5: sum of squares
	logic          v_s5;
	logic [66:0]   sum_s5;
	logic [63:0]   nmx_s5, nmy_s5;
	slsp_pkg::carry_t c_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		sum_s5 <= 67'(sqx_s4) + 67'(sqy_s4);
		nmx_s5 <= nmx_s4;
		nmy_s5 <= nmy_s4;
		c_s5   <= c_s4;
	end

	// square root, one result bit per stage
	logic             sq_v_s    [SQ_N];
	logic [66:0]      sq_rem_s  [SQ_N];
	logic [SQ_N-1:0]  sq_root_s [SQ_N];
	logic [63:0]      sq_nmx_s  [SQ_N];
	logic [63:0]      sq_nmy_s  [SQ_N];
	slsp_pkg::carry_t sq_c_s    [SQ_N];

	for (genvar i = 0; i < SQ_N; i++) begin : g_sq
		localparam int B = SQ_N - 1 - i;
		logic             vin;
		logic [66:0]      rin;
		logic [SQ_N-1:0]  oin;
		logic [63:0]      nxin, nyin;
		slsp_pkg::carry_t cin;
		logic [67:0]      trial;
		logic             take;

		if (i == 0) begin : g_first
			assign vin  = v_s5;
			assign rin  = sum_s5;
			assign oin  = '0;
			assign nxin = nmx_s5;
			assign nyin = nmy_s5;
			assign cin  = c_s5;
		end else begin : g_next
			assign vin  = sq_v_s[i-1];
			assign rin  = sq_rem_s[i-1];
			assign oin  = sq_root_s[i-1];
			assign nxin = sq_nmx_s[i-1];
			assign nyin = sq_nmy_s[i-1];
			assign cin  = sq_c_s[i-1];
		end

		assign trial = (68'(oin) << (B + 1)) | (68'd1 << (2 * B));
		assign take  = trial <= {1'b0, rin};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[i] <= 1'b0;
			else
				sq_v_s[i] <= vin;
		end

		always_ff @(posedge clk) begin
			sq_rem_s[i]  <= take ? rin - trial[66:0] : rin;
			sq_root_s[i] <= take ? (oin | (SQ_N'(1) << B)) : oin;
			sq_nmx_s[i]  <= nxin;
			sq_nmy_s[i]  <= nyin;
			sq_c_s[i]    <= cin;
		end
	end

	// clip decision
	logic             v_cl_q;
	logic             clip_cl_q;
	logic [SQ_N-1:0]  t_cl_q;
	logic [63:0]      nmx_cl_q, nmy_cl_q;
	slsp_pkg::carry_t c_cl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_cl_q <= 1'b0;
		else
			v_cl_q <= sq_v_s[SQ_N-1];
	end

	always_ff @(posedge clk) begin
		t_cl_q    <= sq_root_s[SQ_N-1];
		clip_cl_q <= sq_root_s[SQ_N-1] > SQ_N'(step_q);
		nmx_cl_q  <= sq_nmx_s[SQ_N-1];
		nmy_cl_q  <= sq_nmy_s[SQ_N-1];
		c_cl_q    <= sq_c_s[SQ_N-1];
	end

	// dividers for x and y, one quotient bit per stage
	logic             dv_v_s    [DV_N];
	logic             dv_clip_s [DV_N];
	logic [SQ_N-1:0]  dv_t_s    [DV_N];
	logic [63:0]      dv_rx_s   [DV_N];
	logic [63:0]      dv_ry_s   [DV_N];
	logic [DV_N-1:0]  dv_qx_s   [DV_N];
	logic [DV_N-1:0]  dv_qy_s   [DV_N];
	slsp_pkg::carry_t dv_c_s    [DV_N];

	for (genvar j = 0; j < DV_N; j++) begin : g_dv
		localparam int K = DV_N - 1 - j;
		logic             vin, clin;
		logic [SQ_N-1:0]  tin;
		logic [63:0]      rxin, ryin;
		logic [DV_N-1:0]  qxin, qyin;
		slsp_pkg::carry_t cin;
		logic [64:0]      dsh;
		logic             tx, ty;

		if (j == 0) begin : g_first
			assign vin  = v_cl_q;
			assign clin = clip_cl_q;
			assign tin  = t_cl_q;
			assign rxin = nmx_cl_q;
			assign ryin = nmy_cl_q;
			assign qxin = '0;
			assign qyin = '0;
			assign cin  = c_cl_q;
		end else begin : g_next
			assign vin  = dv_v_s[j-1];
			assign clin = dv_clip_s[j-1];
			assign tin  = dv_t_s[j-1];
			assign rxin = dv_rx_s[j-1];
			assign ryin = dv_ry_s[j-1];
			assign qxin = dv_qx_s[j-1];
			assign qyin = dv_qy_s[j-1];
			assign cin  = dv_c_s[j-1];
		end

		assign dsh = 65'(tin) << K;
		assign tx  = dsh <= {1'b0, rxin};
		assign ty  = dsh <= {1'b0, ryin};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j] <= 1'b0;
			else
				dv_v_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			dv_rx_s[j]   <= tx ? rxin - dsh[63:0] : rxin;
			dv_ry_s[j]   <= ty ? ryin - dsh[63:0] : ryin;
			dv_qx_s[j]   <= tx ? (qxin | (DV_N'(1) << K)) : qxin;
			dv_qy_s[j]   <= ty ? (qyin | (DV_N'(1) << K)) : qyin;
			dv_clip_s[j] <= clin;
			dv_t_s[j]    <= tin;
			dv_c_s[j]    <= cin;
		end
	end

	// unclipped z needs the raw error magnitude; carry it beside the pipeline
	logic [CW:0] ezm_q [SQ_N + DV_N + 4];

	for (genvar k = 0; k < SQ_N + DV_N + 4; k++) begin : g_ez
		if (k == 0) begin : g_first
			always_ff @(posedge clk) ezm_q[k] <= mez_s2;
		end else begin : g_next
			always_ff @(posedge clk) ezm_q[k] <= ezm_q[k-1];
		end
	end

	// output: select, add, saturate
	slsp_pkg::carry_t cf;
	logic             clf;
	logic [slsp_pkg::MZ_W-1:0] mxf, myf, mzf;

	assign cf  = dv_c_s[DV_N-1];
	assign clf = dv_clip_s[DV_N-1];
	assign mxf = clf ? slsp_pkg::MZ_W'(dv_qx_s[DV_N-1]) : slsp_pkg::MZ_W'(cf.mx);
	assign myf = clf ? slsp_pkg::MZ_W'(dv_qy_s[DV_N-1]) : slsp_pkg::MZ_W'(cf.my);
	assign mzf = clf ? cf.mz : slsp_pkg::MZ_W'(ezm_q[SQ_N + DV_N + 3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_v_s[DV_N-1];
	end

	always_ff @(posedge clk) begin
		next_x       <= slsp_pkg::sat(slsp_pkg::add_mag(cf.cx, cf.sx, mxf));
		next_y       <= slsp_pkg::sat(slsp_pkg::add_mag(cf.cy, cf.sy, myf));
		next_z       <= slsp_pkg::sat(slsp_pkg::add_mag(cf.cz, cf.sz, mzf));
		step_clipped <= clf;
	end

endmodule

@@ bench/tb.sv @@
// Testbench for step_limited_setpoint_planner: directed table and random checks.
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        c;
	} setpoint_t;

	typedef struct {
		logic [31:0] d [3];
		logic [31:0] p [3];
		logic        typed;
		setpoint_t   want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] dest_x, dest_y, dest_z, cur_x, cur_y, cur_z;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [31:0] next_x, next_y, next_z;
	logic        step_clipped;

	logic [16:0] damping;
	logic [30:0] step_lim;
	setpoint_t   pending_q[$];
	logic        typed_q[$];
	setpoint_t   typed_val_q[$];
	int          errors;
	int          quiet_cycles;
	bit          idle_on;

	step_limited_setpoint_planner DUT (.*);

	always #2 clk = ~clk;

	function automatic logic signed [63:0] wid(logic [31:0] v);
		return $signed({{32{v[31]}}, v});
	endfunction

	function automatic logic [63:0] absval(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic setpoint_t plan_next(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		logic signed [63:0] ex, eyr, ez, ox, oy, oz;
		logic [63:0]        alpha, stp, mx, my, t;
		logic [127:0]       sum, cand, qx, qy, mz;
		setpoint_t          r;
		alpha = damping > 17'd65536 ? 64'd65536 : 64'(damping);
		stp = 64'(step_lim);
		ex = wid(dx) - wid(px);
		eyr = wid(dy) - wid(py);
		ez = wid(dz) - wid(pz);
		mx = absval(ex);
		my = (absval(eyr) * (64'd65536 - alpha)) >> 16;
		sum = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
		t = 0;
		for (int b = 40; b >= 0; b--) begin
			cand = 128'(t) | (128'd1 << b);
			if (cand * cand <= sum)
				t = cand[63:0];
		end
		r.c = t > stp;
		if (r.c) begin
			mz = (128'(stp) * 128'(absval(ez))) >> 16;
			if (mz > (128'd1 << 62))
				mz = 128'd1 << 62;
			qx = (128'(stp) * 128'(mx)) / 128'(t);
			qy = (128'(stp) * 128'(my)) / 128'(t);
			ox = ex < 0 ? wid(px) - $signed(qx[63:0]) : wid(px) + $signed(qx[63:0]);
			oy = eyr < 0 ? wid(py) - $signed(qy[63:0]) : wid(py) + $signed(qy[63:0]);
			oz = ez < 0 ? wid(pz) - $signed(mz[63:0]) : wid(pz) + $signed(mz[63:0]);
		end else begin
			ox = wid(px) + ex;
			oy = eyr < 0 ? wid(py) - $signed(my) : wid(py) + $signed(my);
			oz = wid(pz) + ez;
		end
		r.x = clamp32(ox);
		r.y = clamp32(oy);
		r.z = clamp32(oz);
		return r;
	endfunction

	always @(posedge clk) begin
		setpoint_t got, want;
		if (done) begin
			got = '{next_x, next_y, next_z, step_clipped};
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result x=%h y=%h z=%h clip=%b", $time,
					got.x, got.y, got.z, got.c);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch expected x=%h y=%h z=%h clip=%b", $time,
						want.x, want.y, want.z, want.c);
					$display("%0t:          actual   x=%h y=%h z=%h clip=%b", $time,
						got.x, got.y, got.z, got.c);
				end
			end
		end
		if (start && !busy) begin
			want = plan_next(dest_x, dest_y, dest_z, cur_x, cur_y, cur_z);
			if (typed_q.pop_front()) begin
				got = typed_val_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: table row expected x=%h y=%h z=%h clip=%b", $time,
						got.x, got.y, got.z, got.c);
					$display("%0t:      predictor     x=%h y=%h z=%h clip=%b", $time,
						want.x, want.y, want.z, want.c);
				end
				want = got;
			end
			pending_q.push_back(want);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("FAIL step_limited_setpoint_planner");
			$finish;
		end
	end

	task automatic put_item(logic [31:0] d[3], logic [31:0] p[3], logic typed,
			setpoint_t want);
		if (idle_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		typed_q.push_back(typed);
		if (typed)
			typed_val_q.push_back(want);
		start <= 1'b1;
		{dest_x, dest_y, dest_z} <= {d[0], d[1], d[2]};
		{cur_x, cur_y, cur_z} <= {p[0], p[1], p[2]};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(slsp_pkg::reg_idx_t idx, logic [31:0] val);
		start <= 1'b0;
		@(posedge clk);
		wait (pending_q.size() == 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == slsp_pkg::REG_DAMPING)
			damping = val[16:0];
		else
			step_lim = val[30:0];
	endtask

	function automatic logic [31:0] rand_coord(int mode, logic [31:0] base);
		case (mode)
			0: return $urandom();
			1: return base + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			2: return base + 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
			default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
				: 32'h80000000 + $urandom_range(3);
		endcase
	endfunction

	initial begin
		stim_row_t   rows[$];
		stim_row_t   r;
		logic [31:0] d[3], p[3];
		int          mode;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = slsp_pkg::REG_DAMPING;
		cfg_data = '0;
		{dest_x, dest_y, dest_z, cur_x, cur_y, cur_z} = '0;
		damping = slsp_pkg::ALPHA_RESET;
		step_lim = slsp_pkg::STEP_RESET;
		errors = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;

		r = '{'{0, 0, 0}, '{0, 0, 0}, 1'b1, '{0, 0, 0, 1'b0}};
		rows.push_back(r);
		r = '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
			'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1'b1,
			'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0}};
		rows.push_back(r);
		r = '{'{32'h80000000, 32'h80000000, 32'h80000000},
			'{32'h80000000, 32'h80000000, 32'h80000000}, 1'b1,
			'{32'h80000000, 32'h80000000, 32'h80000000, 1'b0}};
		rows.push_back(r);
		r = '{'{32'h7fffffff, 0, 0}, '{32'h80000000, 0, 0}, 1'b1,
			'{32'h80000000 + 32'(slsp_pkg::STEP_RESET), 0, 0, 1'b1}};
		rows.push_back(r);
		r = '{'{32'h80000000, 0, 0}, '{32'h7fffffff, 0, 0}, 1'b1,
			'{32'h7fffffff - 32'(slsp_pkg::STEP_RESET), 0, 0, 1'b1}};
		rows.push_back(r);
		r = '{'{0, 32'h7fffffff, 32'h7fffffff}, '{0, 32'h80000000, 32'h80000000}, 1'b0,
			'{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{'{0, 32'h80000000, 32'h80000000}, '{0, 32'h7fffffff, 32'h7fffffff}, 1'b0,
			'{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{'{32'd19661, 0, 32'd100}, '{0, 0, 0}, 1'b1, '{32'd19661, 0, 32'd100, 1'b0}};
		rows.push_back(r);
		r = '{'{32'd19662, 0, 32'd65536}, '{0, 0, 0}, 1'b0, '{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{'{32'hffffb333, 32'd39322, 32'hffff0000}, '{0, 0, 0}, 1'b0, '{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{'{32'd1, 32'd3, 32'hffffffff}, '{32'hffffffff, 32'hffffffff, 32'd1}, 1'b0,
			'{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{'{32'h00030000, 32'h00040000, 32'h12345678},
			'{32'hfffd0000, 32'hfffc0000, 32'hedcba987}, 1'b0, '{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{'{32'h55555555, 32'haaaaaaaa, 32'h55555555},
			'{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa}, 1'b0, '{0, 0, 0, 0}};
		rows.push_back(r);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			put_item(rows[i].d, rows[i].p, rows[i].typed, rows[i].want);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: ;
				1: begin
					write_reg(slsp_pkg::REG_DAMPING, 32'd0);
					write_reg(slsp_pkg::REG_STEP, 32'd0);
				end
				2: begin
					write_reg(slsp_pkg::REG_DAMPING, 32'd65536);
					write_reg(slsp_pkg::REG_STEP, 32'h7fffffff);
				end
				3: begin
					write_reg(slsp_pkg::REG_DAMPING, 32'hffffffff);
					write_reg(slsp_pkg::REG_STEP, 32'h00010000);
				end
				4: begin
					write_reg(slsp_pkg::REG_DAMPING, $urandom());
					write_reg(slsp_pkg::REG_STEP, $urandom());
				end
				5: begin
					write_reg(slsp_pkg::REG_DAMPING, $urandom_range(65536));
					write_reg(slsp_pkg::REG_STEP, $urandom_range(1 << 22));
				end
				default: begin
					write_reg(slsp_pkg::REG_DAMPING, 32'd19661);
					write_reg(slsp_pkg::REG_STEP, 32'h7ffffff0 + $urandom_range(15));
				end
			endcase
			idle_on = phase != 2;
			for (int n = 0; n < 162; n++) begin
				if (n == 80) begin
					start <= 1'b0;
					@(posedge clk);
					wait (pending_q.size() == 0);
					@(posedge clk);
				end
				mode = $urandom_range(9);
				for (int k = 0; k < 3; k++) begin
					p[k] = $urandom();
					d[k] = mode < 3 ? $urandom()
						: rand_coord(mode < 6 ? 1 : mode < 9 ? 2 : 3, p[k]);
				end
				if (mode == 9)
					foreach (p[k]) p[k] = rand_coord(3, 0);
				put_item(d, p, 1'b0, '{0, 0, 0, 0});
			end
		end

		start <= 1'b0;
		@(posedge clk);
		wait (pending_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("PASS step_limited_setpoint_planner");
		else
			$display("FAIL step_limited_setpoint_planner");
		$finish;
	end

endmodule
